// ----- design/drt_pkg.sv -----
// Shared types, register map and bit positions for the dual reload down timer.
package drt_pkg;

    localparam int DEFAULT_COUNT_WIDTH = 32;
    localparam int WORD_WIDTH          = 32;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [2:0] REG_RELOAD0  = 3'd0;
    localparam logic [2:0] REG_RELOAD1  = 3'd1;
    localparam logic [2:0] REG_COUNT0   = 3'd2;
    localparam logic [2:0] REG_COUNT1   = 3'd3;
    localparam logic [2:0] REG_CONTROL  = 3'd4;
    localparam logic [2:0] REG_IRQ      = 3'd5;
    localparam logic [2:0] REG_UNUSED6  = 3'd6;
    localparam logic [2:0] REG_UNUSED7  = 3'd7;

    // Control word layout.
    localparam int CTL_EN0_BIT   = 31;
    localparam int CTL_MODE0_BIT = 30;
    localparam int CTL_EN1_BIT   = 29;
    localparam int CTL_MODE1_BIT = 28;

    // Interrupt word layout, including the init alias clear bits.
    localparam int IRQ_EN0_BIT       = 31;
    localparam int IRQ_EN1_BIT       = 30;
    localparam int IRQ_PEND0_BIT     = 29;
    localparam int IRQ_PEND1_BIT     = 28;
    localparam int IRQ_ALIAS_CLR0_BIT = 5;
    localparam int IRQ_ALIAS_CLR1_BIT = 4;

    typedef struct packed {
        logic tick;
        logic wr_reload;
        logic wr_count;
        logic wr_control;
        logic enable_val;
        logic mode_val;
        logic wr_irq;
        logic irq_en_val;
        logic clr_pending;
    } timer_cmd_t;

    typedef struct packed {
        logic enable;
        logic mode;
        logic irq_en;
        logic pending;
    } timer_status_t;

endpackage

// ----- design/drt_req_if.sv -----
// Request channel carrying bus accesses and counting ticks.
interface drt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [2:0]  reg_index;
    logic [31:0] write_data;

    modport source (output valid, output command, output reg_index, output write_data,
                    input ready);
    modport sink   (input valid, input command, input reg_index, input write_data,
                    output ready);
endinterface

// ----- design/drt_rsp_if.sv -----
// Response channel carrying read data, interrupt level and address error.
interface drt_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        irq;
    logic        bad_address;

    modport source (output valid, output read_data, output irq, output bad_address,
                    input ready);
    modport sink   (input valid, input read_data, input irq, input bad_address,
                    output ready);
endinterface

// ----- design/dual_reload_down_timer.sv -----
// Top level of the dual reload down timer with its bus decode and result register.
// A result appears in the cycle after its request beat is accepted.
// One beat per cycle unless rsp stalls; the result register frees itself as it is taken.
// Reset clears both timers, all control bits and the result register.
// Timer state is updated at the accepting edge, so the next beat sees it at once.
module dual_reload_down_timer
    import drt_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    drt_req_if.sink   req,
    drt_rsp_if.source rsp
);

    logic                   accept;
    cmd_t                   command;
    logic                   is_access;
    logic                   mapped;
    logic                   do_write;
    logic [COUNT_WIDTH-1:0] wdata_count;
    timer_cmd_t             tcmd0, tcmd1;
    logic [COUNT_WIDTH-1:0] reload0, reload1, count0, count1;
    timer_status_t          stat0, stat1;
    logic                   irq0_next, irq1_next;
    logic [31:0]            read_word;

    logic                   valid_reg;
    logic [31:0]            read_data_reg;
    logic                   irq_reg;
    logic                   bad_reg;

    assign req.ready   = !valid_reg || rsp.ready;
    assign accept      = req.valid && req.ready;
    assign command     = cmd_t'(req.command);
    assign is_access   = (command == CMD_READ) || (command == CMD_WRITE);
    assign mapped      = (req.reg_index != REG_UNUSED6) && (req.reg_index != REG_UNUSED7);
    assign do_write    = accept && (command == CMD_WRITE) && mapped;
    assign wdata_count = COUNT_WIDTH'(req.write_data);

    always_comb
    begin
        tcmd0 = '0;
        tcmd1 = '0;
        tcmd0.tick        = accept && (command == CMD_TICK);
        tcmd1.tick        = accept && (command == CMD_TICK);
        tcmd0.enable_val  = req.write_data[CTL_EN0_BIT];
        tcmd0.mode_val    = req.write_data[CTL_MODE0_BIT];
        tcmd1.enable_val  = req.write_data[CTL_EN1_BIT];
        tcmd1.mode_val    = req.write_data[CTL_MODE1_BIT];
        tcmd0.irq_en_val  = req.write_data[IRQ_EN0_BIT];
        tcmd1.irq_en_val  = req.write_data[IRQ_EN1_BIT];
        tcmd0.clr_pending = req.write_data[IRQ_PEND0_BIT] || req.write_data[IRQ_ALIAS_CLR0_BIT];
        tcmd1.clr_pending = req.write_data[IRQ_PEND1_BIT] || req.write_data[IRQ_ALIAS_CLR1_BIT];
        if (do_write)
        begin
            unique case (req.reg_index)
                REG_RELOAD0: tcmd0.wr_reload = 1'b1;
                REG_RELOAD1: tcmd1.wr_reload = 1'b1;
                REG_COUNT0:  tcmd0.wr_count  = 1'b1;
                REG_COUNT1:  tcmd1.wr_count  = 1'b1;
                REG_CONTROL:
                begin
                    tcmd0.wr_control = 1'b1;
                    tcmd1.wr_control = 1'b1;
                end
                REG_IRQ:
                begin
                    tcmd0.wr_irq = 1'b1;
                    tcmd1.wr_irq = 1'b1;
                end
                default: ;
            endcase
        end
    end

    drt_timer #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_timer0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (tcmd0),
        .wdata    (wdata_count),
        .reload   (reload0),
        .count    (count0),
        .status   (stat0),
        .irq_next (irq0_next)
    );

    drt_timer #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_timer1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (tcmd1),
        .wdata    (wdata_count),
        .reload   (reload1),
        .count    (count1),
        .status   (stat1),
        .irq_next (irq1_next)
    );

    always_comb
    begin
        read_word = '0;
        if (command == CMD_READ)
        begin
            unique case (req.reg_index)
                REG_RELOAD0: read_word = 32'(reload0);
                REG_RELOAD1: read_word = 32'(reload1);
                REG_COUNT0:  read_word = 32'(count0);
                REG_COUNT1:  read_word = 32'(count1);
                REG_CONTROL:
                begin
                    read_word[CTL_EN0_BIT]   = stat0.enable;
                    read_word[CTL_MODE0_BIT] = stat0.mode;
                    read_word[CTL_EN1_BIT]   = stat1.enable;
                    read_word[CTL_MODE1_BIT] = stat1.mode;
                end
                REG_IRQ:
                begin
                    read_word[IRQ_EN0_BIT]   = stat0.irq_en;
                    read_word[IRQ_EN1_BIT]   = stat1.irq_en;
                    read_word[IRQ_PEND0_BIT] = stat0.pending;
                    read_word[IRQ_PEND1_BIT] = stat1.pending;
                end
                default: read_word = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_data_reg <= '0;
            irq_reg       <= 1'b0;
            bad_reg       <= 1'b0;
        end
        else if (accept)
        begin
            read_data_reg <= read_word;
            irq_reg       <= irq0_next || irq1_next;
            bad_reg       <= is_access && !mapped;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.read_data   = read_data_reg;
    assign rsp.irq         = irq_reg;
    assign rsp.bad_address = bad_reg;

endmodule

// ----- design/drt_timer.sv -----
// One down-counting timer with its reload, control and interrupt state.
module drt_timer
    import drt_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  timer_cmd_t             cmd,
    input  logic [COUNT_WIDTH-1:0] wdata,
    output logic [COUNT_WIDTH-1:0] reload,
    output logic [COUNT_WIDTH-1:0] count,
    output timer_status_t          status,
    output logic                   irq_next
);

    logic [COUNT_WIDTH-1:0] reload_reg, reload_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    timer_status_t          status_reg, status_next;
    logic                   expiring;

    assign expiring = (count_reg[COUNT_WIDTH-1:1] == '0);

    always_comb
    begin
        reload_next = reload_reg;
        count_next  = count_reg;
        status_next = status_reg;
        if (cmd.wr_reload)
        begin
            reload_next = wdata;
        end
        if (cmd.wr_count)
        begin
            count_next = wdata;
        end
        if (cmd.wr_control)
        begin
            status_next.enable = cmd.enable_val;
            status_next.mode   = cmd.mode_val;
        end
        if (cmd.wr_irq)
        begin
            status_next.irq_en = cmd.irq_en_val;
            if (cmd.clr_pending)
            begin
                status_next.pending = 1'b0;
            end
        end
        if (cmd.tick && status_reg.enable)
        begin
            if (expiring)
            begin
                status_next.pending = 1'b1;
                if (status_reg.mode)
                begin
                    count_next = reload_reg;
                end
                else
                begin
                    count_next         = '0;
                    status_next.enable = 1'b0;
                end
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg <= '0;
            count_reg  <= '0;
            status_reg <= '0;
        end
        else
        begin
            reload_reg <= reload_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    assign reload   = reload_reg;
    assign count    = count_reg;
    assign status   = status_reg;
    assign irq_next = status_next.irq_en && status_next.pending;

endmodule
